// ----- sv/lcal_pkg.sv -----
// Shared widths, defaults and codes for the lowest common ancestor lifting block.
`timescale 1ns / 1ps
`default_nettype none

package lcal_pkg;

  localparam int ID_W       = 10;
  localparam int DEPTH_W    = 10;
  localparam int DIST_W     = 11;
  localparam int NODES_DEF  = 1024;
  localparam int LEVELS_DEF = 10;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

endpackage

`default_nettype wire

// ----- sv/lowest_common_ancestor_lifting_core.sv -----
// Top level: tree loader and lowest common ancestor query engine by binary lifting.
`timescale 1ns / 1ps
`default_nettype none

// After reset the block sweeps both tables to zero, one ancestor entry per cycle, over
// all NODES*LEVELS ancestor entries (10240 with the defaults) before in_tready first
// rises. One item is worked at a time. For an insert (in_tuser low), each ancestor level
// above level 0 needs one table read whose address is the entry written for the level
// below, then the write of the new entry. An insert of node 0 is dropped at once. A query
// (in_tuser high) reads both depths together, lifts the deeper node one level per cycle,
// then, if the two nodes still differ, lets both climb together one level per cycle on the
// two table read ports; the depth of the ancestor is read for the distance. The result
// sits in an output register, so the next word is taken while it waits.
module lowest_common_ancestor_lifting_core
  import lcal_pkg::*;
#(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // node_a [9:0], node_b [19:10], zero [23:20]
  input  wire         in_tuser,   // opcode [0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata   // ancestor [9:0], distance [20:10], zero [23:21]
);

  localparam int AW       = $clog2(NODES);
  localparam int JT_DEPTH = NODES * LEVELS;
  localparam int CW       = $clog2(JT_DEPTH);
  localparam int LW       = $clog2(LEVELS);
  localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 1);

  localparam logic [3:0] ST_CLR      = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_INS_DP   = 4'd2;
  localparam logic [3:0] ST_INS_RD   = 4'd3;
  localparam logic [3:0] ST_INS_WR   = 4'd4;
  localparam logic [3:0] ST_Q_DP     = 4'd5;
  localparam logic [3:0] ST_LIFT     = 4'd6;
  localparam logic [3:0] ST_LIFT_END = 4'd7;
  localparam logic [3:0] ST_WALK     = 4'd8;
  localparam logic [3:0] ST_FIN      = 4'd9;
  localparam logic [3:0] ST_DEP      = 4'd10;

  function automatic logic [AW-1:0] to_idx(input logic [ID_W-1:0] v);
    return (32'(v) < NODES) ? AW'(v) : '0;
  endfunction

  function automatic logic [CW-1:0] jt_addr(input logic [LW-1:0] lvl, input logic [AW-1:0] node);
    return CW'(lvl) * CW'(NODES) + CW'(node);
  endfunction

  logic [3:0]         state_r, state_nxt;
  logic [CW-1:0]      clr_r, clr_nxt;
  logic [AW-1:0]      a_r, a_nxt;
  logic [AW-1:0]      b_r, b_nxt;
  logic [AW-1:0]      cur_r, cur_nxt;
  logic [AW-1:0]      anc_r, anc_nxt;
  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic               take_r, take_nxt;
  logic [LEVELS-1:0]  diff_r, diff_nxt;
  logic [DIST_W-1:0]  sum_r, sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_anc_r, out_anc_nxt;
  logic [DIST_W-1:0]  out_dist_r, out_dist_nxt;

  logic               jt_we;
  logic [CW-1:0]      jt_waddr, jt_ra_a, jt_ra_b;
  logic [ID_W-1:0]    jt_wdata, jt_rd_a, jt_rd_b;
  logic               ds_we;
  logic [AW-1:0]      ds_waddr, ds_ra_a, ds_ra_b;
  logic [DEPTH_W-1:0] ds_wdata, ds_rd_a, ds_rd_b;

  logic               in_accept;
  logic [AW-1:0]      in_a_idx, in_b_idx;
  logic [AW-1:0]      jt_ua, jt_ub, a_cur, na, nb;
  logic [DEPTH_W-1:0] dep_diff;
  logic [DIST_W-1:0]  twice;

  lcal_tables #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_tables (
    .clk      (clk),
    .jt_we    (jt_we),
    .jt_waddr (jt_waddr),
    .jt_wdata (jt_wdata),
    .jt_ra_a  (jt_ra_a),
    .jt_ra_b  (jt_ra_b),
    .jt_rd_a  (jt_rd_a),
    .jt_rd_b  (jt_rd_b),
    .ds_we    (ds_we),
    .ds_waddr (ds_waddr),
    .ds_wdata (ds_wdata),
    .ds_ra_a  (ds_ra_a),
    .ds_ra_b  (ds_ra_b),
    .ds_rd_a  (ds_rd_a),
    .ds_rd_b  (ds_rd_b)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign in_a_idx   = to_idx(in_tdata[9:0]);
  assign in_b_idx   = to_idx(in_tdata[19:10]);
  assign jt_ua      = to_idx(jt_rd_a);
  assign jt_ub      = to_idx(jt_rd_b);
  assign a_cur      = take_r ? jt_ua : a_r;
  assign na         = (jt_ua != jt_ub) ? jt_ua : a_r;
  assign nb         = (jt_ua != jt_ub) ? jt_ub : b_r;
  assign dep_diff   = (ds_rd_b > ds_rd_a) ? (ds_rd_b - ds_rd_a) : (ds_rd_a - ds_rd_b);
  assign twice      = {ds_rd_a, 1'b0};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_dist_r, out_anc_r};

  for (genvar g = 0; g < LEVELS; g++) begin : g_diff
    if (g < DEPTH_W) begin : g_bit
      assign diff_nxt[g] = (state_r == ST_Q_DP) ? dep_diff[g] : diff_r[g];
    end else begin : g_zero
      assign diff_nxt[g] = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    anc_nxt       = anc_r;
    lvl_nxt       = lvl_r;
    take_nxt      = take_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_anc_nxt   = out_anc_r;
    out_dist_nxt  = out_dist_r;
    jt_we         = 1'b0;
    jt_waddr      = jt_addr(lvl_r, a_r);
    jt_wdata      = '0;
    jt_ra_a       = jt_addr(lvl_r, a_r);
    jt_ra_b       = jt_addr(lvl_r, b_r);
    ds_we         = 1'b0;
    ds_waddr      = a_r;
    ds_wdata      = '0;
    ds_ra_a       = anc_r;
    ds_ra_b       = in_b_idx;
    unique case (state_r)
      ST_CLR: begin
        jt_we    = 1'b1;
        jt_waddr = clr_r;
        ds_we    = (clr_r < CW'(NODES));
        ds_waddr = AW'(clr_r);
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == CW'(JT_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ds_ra_a = in_a_idx;
        if (in_accept) begin
          a_nxt = in_a_idx;
          b_nxt = in_b_idx;
          if (in_tuser == OP_QUERY) begin
            state_nxt = ST_Q_DP;
          end else if (in_a_idx != '0) begin
            state_nxt = ST_INS_DP;
          end
        end
      end
      ST_INS_DP: begin
        ds_we     = 1'b1;
        ds_waddr  = a_r;
        ds_wdata  = (ds_rd_b == DEPTH_MAX) ? DEPTH_MAX : ds_rd_b + 1'b1;
        jt_we     = 1'b1;
        jt_waddr  = jt_addr('0, a_r);
        jt_wdata  = ID_W'(b_r);
        cur_nxt   = b_r;
        lvl_nxt   = LW'(1);
        state_nxt = ST_INS_RD;
      end
      ST_INS_RD: begin
        jt_ra_a   = jt_addr(LW'(lvl_r - 1'b1), cur_r);
        state_nxt = ST_INS_WR;
      end
      ST_INS_WR: begin
        jt_we    = 1'b1;
        jt_waddr = jt_addr(lvl_r, a_r);
        jt_wdata = jt_rd_a;
        cur_nxt  = jt_ua;
        if (lvl_r == LVL_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = ST_INS_RD;
        end
      end
      ST_Q_DP: begin
        if (ds_rd_b > ds_rd_a) begin
          a_nxt = b_r;
          b_nxt = a_r;
        end
        sum_nxt   = DIST_W'(ds_rd_a) + DIST_W'(ds_rd_b);
        lvl_nxt   = '0;
        take_nxt  = 1'b0;
        state_nxt = ST_LIFT;
      end
      ST_LIFT: begin
        a_nxt    = a_cur;
        jt_ra_a  = jt_addr(lvl_r, a_cur);
        take_nxt = diff_r[lvl_r];
        if (lvl_r == LVL_LAST) begin
          state_nxt = ST_LIFT_END;
        end else begin
          lvl_nxt = lvl_r + 1'b1;
        end
      end
      ST_LIFT_END: begin
        a_nxt = a_cur;
        if (a_cur == b_r) begin
          anc_nxt   = a_cur;
          ds_ra_a   = a_cur;
          state_nxt = ST_DEP;
        end else begin
          jt_ra_a   = jt_addr(LVL_LAST, a_cur);
          jt_ra_b   = jt_addr(LVL_LAST, b_r);
          lvl_nxt   = LVL_LAST;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        a_nxt = na;
        b_nxt = nb;
        if (lvl_r == '0) begin
          jt_ra_a   = jt_addr('0, na);
          state_nxt = ST_FIN;
        end else begin
          jt_ra_a = jt_addr(LW'(lvl_r - 1'b1), na);
          jt_ra_b = jt_addr(LW'(lvl_r - 1'b1), nb);
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      ST_FIN: begin
        anc_nxt   = jt_ua;
        ds_ra_a   = jt_ua;
        state_nxt = ST_DEP;
      end
      ST_DEP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_anc_nxt   = ID_W'(anc_r);
          out_dist_nxt  = (sum_r > twice) ? (sum_r - twice) : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    cur_r      <= cur_nxt;
    anc_r      <= anc_nxt;
    lvl_r      <= lvl_nxt;
    take_r     <= take_nxt;
    diff_r     <= diff_nxt;
    sum_r      <= sum_nxt;
    out_anc_r  <= out_anc_nxt;
    out_dist_r <= out_dist_nxt;
  end

`ifndef ASSERT_OFF
  a_no_sentinel_write: assert property (@(posedge clk) disable iff (!rst_n)
    (jt_we && state_r != ST_CLR) |-> (a_r != '0))
    else $error("ancestor row of the sentinel node written");

  a_insert_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser == OP_INSERT) |=> !$rose(out_valid_r))
    else $error("insert produced a result");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DEP))
    else $error("result raised outside the distance step");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIFT || state_r == ST_WALK || state_r == ST_INS_WR) |-> (lvl_r <= LVL_LAST))
    else $error("lifting level beyond the table");
`endif

endmodule

`default_nettype wire

// ----- sv/lcal_tables.sv -----
// Ancestor table and depth store, each with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module lcal_tables
  import lcal_pkg::*;
#(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  wire                                  clk,
  input  wire                                  jt_we,
  input  wire  [$clog2(NODES*LEVELS)-1:0]      jt_waddr,
  input  wire  [ID_W-1:0]                      jt_wdata,
  input  wire  [$clog2(NODES*LEVELS)-1:0]      jt_ra_a,
  input  wire  [$clog2(NODES*LEVELS)-1:0]      jt_ra_b,
  output logic [ID_W-1:0]                      jt_rd_a,
  output logic [ID_W-1:0]                      jt_rd_b,
  input  wire                                  ds_we,
  input  wire  [$clog2(NODES)-1:0]             ds_waddr,
  input  wire  [DEPTH_W-1:0]                   ds_wdata,
  input  wire  [$clog2(NODES)-1:0]             ds_ra_a,
  input  wire  [$clog2(NODES)-1:0]             ds_ra_b,
  output logic [DEPTH_W-1:0]                   ds_rd_a,
  output logic [DEPTH_W-1:0]                   ds_rd_b
);

  localparam int JT_DEPTH = NODES * LEVELS;

  logic [ID_W-1:0]    jt_mem [JT_DEPTH];
  logic [DEPTH_W-1:0] ds_mem [NODES];

  always_ff @(posedge clk) begin
    if (jt_we) begin
      jt_mem[jt_waddr] <= jt_wdata;
    end
    jt_rd_a <= jt_mem[jt_ra_a];
    jt_rd_b <= jt_mem[jt_ra_b];
  end

  always_ff @(posedge clk) begin
    if (ds_we) begin
      ds_mem[ds_waddr] <= ds_wdata;
    end
    ds_rd_a <= ds_mem[ds_ra_a];
    ds_rd_b <= ds_mem[ds_ra_b];
  end

endmodule

`default_nettype wire

// ----- sim/tb_lowest_common_ancestor_lifting_core.sv -----
// Testbench for the binary lifting common ancestor core: table, random tree traffic, depth climb.
`timescale 1ns / 1ps
`default_nettype none

module tb_lowest_common_ancestor_lifting_core;
  import lcal_pkg::*;

  localparam int NODES     = NODES_DEF;
  localparam int LEVELS    = LEVELS_DEF;
  localparam int RAND_GOAL = 330;
  localparam int CLIMB_LEN = 80;
  localparam int HOLD_LEN  = 500;
  localparam int LIMIT     = 400000;

  typedef logic [ID_W-1:0]    node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef struct packed {
    node_t anc;
    dist_t path_len;
  } answer_t;

  typedef struct packed {
    logic  op;
    node_t a;
    node_t b;
    logic  typed;
    node_t anc;
    dist_t path_len;
  } plan_row_t;

  localparam int PLAN_LEN = 23;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{OP_QUERY,  10'd0,    10'd0,    1'b1, 10'd0,    11'd0},
    '{OP_QUERY,  10'd1023, 10'd1023, 1'b1, 10'd1023, 11'd0},
    '{OP_QUERY,  10'd5,    10'd1023, 1'b1, 10'd0,    11'd0},
    '{OP_INSERT, 10'd0,    10'd7,    1'b0, 10'd0,    11'd0},
    '{OP_QUERY,  10'd0,    10'd7,    1'b1, 10'd0,    11'd0},
    '{OP_INSERT, 10'd1,    10'd0,    1'b0, 10'd0,    11'd0},
    '{OP_INSERT, 10'd1023, 10'd1,    1'b0, 10'd0,    11'd0},
    '{OP_QUERY,  10'd1023, 10'd1,    1'b1, 10'd1,    11'd1},
    '{OP_QUERY,  10'd1023, 10'd0,    1'b1, 10'd0,    11'd2},
    '{OP_INSERT, 10'd2,    10'd1,    1'b0, 10'd0,    11'd0},
    '{OP_INSERT, 10'd3,    10'd2,    1'b0, 10'd0,    11'd0},
    '{OP_INSERT, 10'd4,    10'd3,    1'b0, 10'd0,    11'd0},
    '{OP_QUERY,  10'd4,    10'd1023, 1'b0, 10'd0,    11'd0},
    '{OP_QUERY,  10'd1023, 10'd4,    1'b0, 10'd0,    11'd0},
    '{OP_INSERT, 10'd682,  10'd1023, 1'b0, 10'd0,    11'd0},
    '{OP_INSERT, 10'd341,  10'd682,  1'b0, 10'd0,    11'd0},
    '{OP_QUERY,  10'd341,  10'd4,    1'b0, 10'd0,    11'd0},
    '{OP_INSERT, 10'd5,    10'd5,    1'b0, 10'd0,    11'd0},
    '{OP_QUERY,  10'd5,    10'd1,    1'b0, 10'd0,    11'd0},
    '{OP_INSERT, 10'd3,    10'd1023, 1'b0, 10'd0,    11'd0},
    '{OP_QUERY,  10'd4,    10'd2,    1'b0, 10'd0,    11'd0},
    '{OP_QUERY,  10'd4,    10'd3,    1'b0, 10'd0,    11'd0},
    '{OP_QUERY,  10'd1,    10'd1,    1'b1, 10'd1,    11'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [23:0] out_tdata;

  lowest_common_ancestor_lifting_core #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted tree state
  node_t   ancestor_row [NODES][LEVELS];
  depth_t  node_depth [NODES];
  answer_t pending_answers [$];

  bit      in_tree [NODES];
  node_t   tree_nodes [$];
  node_t   last_inserted;

  int      cycle_count = 0;
  int      fails = 0;
  int      answers_seen = 0;
  int      inserts_sent = 0;
  int      dropped_sent = 0;
  int      queries_sent = 0;
  int      deepest = 0;
  bit      steady = 1'b0;
  bit      held = 1'b0;

  function automatic void tree_insert(node_t n, node_t p);
    depth_t d;
    if (n == '0) return;
    d = (node_depth[p] == DEPTH_MAX) ? DEPTH_MAX : node_depth[p] + 1'b1;
    node_depth[n] = d;
    ancestor_row[n][0] = p;
    for (int i = 1; i < LEVELS; i++)
      ancestor_row[n][i] = ancestor_row[ancestor_row[n][i-1]][i-1];
    if (int'(d) > deepest) deepest = int'(d);
  endfunction

  function automatic answer_t common_ancestor_of(node_t a, node_t b);
    node_t   x;
    node_t   y;
    node_t   ux;
    node_t   uy;
    depth_t  diff;
    int      sum;
    int      twice;
    answer_t r;
    x = a;
    y = b;
    if (node_depth[b] > node_depth[a]) begin
      x = b;
      y = a;
    end
    diff = node_depth[x] - node_depth[y];
    for (int i = 0; i < LEVELS; i++)
      if (diff[i]) x = ancestor_row[x][i];
    if (x != y) begin
      for (int i = LEVELS - 1; i >= 0; i--) begin
        ux = ancestor_row[x][i];
        uy = ancestor_row[y][i];
        if (ux != uy) begin
          x = ux;
          y = uy;
        end
      end
      x = ancestor_row[x][0];
    end
    sum   = int'(node_depth[a]) + int'(node_depth[b]);
    twice = 2 * int'(node_depth[x]);
    r.anc      = x;
    r.path_len = (sum > twice) ? dist_t'(sum - twice) : '0;
    return r;
  endfunction

  // Offer one word from a falling edge; predict once it is taken.
  task automatic send_word(logic op, node_t a, node_t b, logic typed, node_t anc,
                           dist_t path_len);
    answer_t want;
    while (!steady && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_INSERT) begin
      tree_insert(a, b);
      if (a == '0) begin
        dropped_sent++;
      end else begin
        inserts_sent++;
        last_inserted = a;
        if (!in_tree[a]) begin
          in_tree[a] = 1'b1;
          tree_nodes.push_back(a);
        end
      end
    end else begin
      queries_sent++;
      want = common_ancestor_of(a, b);
      if (typed) begin
        want.anc      = anc;
        want.path_len = path_len;
      end
      pending_answers.push_back(want);
    end
    @(negedge clk);
  endtask

  function automatic node_t pick_tree_node();
    if (tree_nodes.size() == 0) return '0;
    return tree_nodes[$urandom_range(tree_nodes.size() - 1)];
  endfunction

  function automatic node_t pick_fresh_node();
    node_t n;
    for (int t = 0; t < 20; t++) begin
      n = node_t'($urandom_range(NODES - 1, 1));
      if (!in_tree[n]) return n;
    end
    return n;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Compare each taken result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("[%0t] unexpected result: ancestor %0d distance %0d", $realtime,
                   out_tdata[9:0], out_tdata[20:10]);
      end else begin
        if (out_tdata[9:0] !== pending_answers[0].anc ||
            out_tdata[20:10] !== pending_answers[0].path_len) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] mismatch: ancestor exp %0d got %0d, distance exp %0d got %0d",
                     $realtime, pending_answers[0].anc, out_tdata[9:0],
                     pending_answers[0].path_len, out_tdata[20:10]);
        end
        void'(pending_answers.pop_front());
      end
    end
  end

  // Receiver: random stalls, one long hold-off once traffic is flowing
  initial begin
    forever begin
      @(negedge clk);
      if (!held && answers_seen >= 40) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_answers.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int    counted;
    int    pick;
    logic  op;
    node_t a;
    node_t b;
    node_t climber;

    for (int n = 0; n < NODES; n++) begin
      node_depth[n] = '0;
      in_tree[n] = 1'b0;
      for (int l = 0; l < LEVELS; l++) ancestor_row[n][l] = '0;
    end
    last_inserted = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < PLAN_LEN; r++)
      send_word(PLAN[r].op, PLAN[r].a, PLAN[r].b, PLAN[r].typed, PLAN[r].anc,
                PLAN[r].path_len);

    // Mostly tree building and queries on loaded nodes, some re-inserts and noise
    counted = 0;
    while (counted < RAND_GOAL) begin
      steady = (counted >= 200 && counted < 300);
      pick = $urandom_range(99);
      if (pick < 40) begin
        op = OP_INSERT;
        a  = pick_fresh_node();
        if (tree_nodes.size() == 0 || $urandom_range(9) == 0) b = '0;
        else if ($urandom_range(1) == 0) b = last_inserted;
        else b = pick_tree_node();
      end else if (pick < 85) begin
        op = OP_QUERY;
        a  = ($urandom_range(19) == 0) ? node_t'(0) : pick_tree_node();
        b  = ($urandom_range(19) == 0) ? node_t'(0) : pick_tree_node();
      end else if (pick < 92) begin
        op = OP_INSERT;
        a  = pick_tree_node();
        b  = ($urandom_range(3) == 0) ? a : pick_tree_node();
      end else begin
        op = logic'($urandom_range(1));
        a  = node_t'($urandom_range(NODES - 1));
        b  = node_t'($urandom_range(NODES - 1));
      end
      if (!(op == OP_INSERT && a == '0)) counted++;
      send_word(op, a, b, 1'b0, '0, '0);
    end
    steady = 1'b0;

    // Climb one node onto itself to build a deep chain
    climber = pick_fresh_node();
    for (int k = 0; k < CLIMB_LEN; k++) begin
      send_word(OP_INSERT, climber, climber, 1'b0, '0, '0);
      if (k % 32 == 31) begin
        send_word(OP_QUERY, climber, '0, 1'b0, '0, '0);
        send_word(OP_QUERY, pick_tree_node(), climber, 1'b0, '0, '0);
      end
    end
    a = pick_fresh_node();
    send_word(OP_INSERT, a, climber, 1'b0, '0, '0);
    send_word(OP_QUERY, a, climber, 1'b0, '0, '0);
    send_word(OP_QUERY, climber, a, 1'b0, '0, '0);
    send_word(OP_QUERY, a, pick_tree_node(), 1'b0, '0, '0);
    in_tvalid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (2 * LEVELS + 20) @(posedge clk);

    $display("Covered %0d inserts (%0d of node zero dropped) and %0d queries, %0d results checked;",
             inserts_sent, dropped_sent, queries_sent, answers_seen);
    $display("tree reached depth %0d with re-inserts and self-parented nodes.",
             deepest);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fails);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
